// ----- rtl/core/ntt_pm_pkg.sv -----
// ----------------------------------------------------------------------------
// ntt_pm_pkg
// shared constants for the ntt polynomial multiplier: modulus, root, codes
// ----------------------------------------------------------------------------
package ntt_pm_pkg;

	// coefficient width and field prime (one spare bit for sums)
	localparam int unsigned CW = 30;
	localparam logic [CW:0] MOD_P = 31'd998244353;

	// floor(2^(2*CW) / p), used by the multiplier to estimate the quotient
	localparam logic [CW:0] RECIP_MU = (CW + 1)'((64'd1 << (2 * CW)) / 64'(MOD_P));

	// primitive root and the odd part of p-1: p-1 = 119 * 2^23
	localparam logic [CW-1:0] ROOT_G = 30'd3;
	localparam logic [6:0] POW_EXP = 7'd119;
	localparam logic [4:0] TWO_ADIC = 5'd23;

	// request codes
	localparam logic [1:0] REQ_LOAD_A = 2'd0;
	localparam logic [1:0] REQ_LOAD_B = 2'd1;
	localparam logic [1:0] REQ_COMPUTE = 2'd2;
	localparam logic [1:0] REQ_READ = 2'd3;

	// result kinds
	localparam logic RES_COEF = 1'b0;
	localparam logic RES_DONE = 1'b1;

	// configuration register indices
	localparam logic [1:0] REG_LEN_A = 2'd0;
	localparam logic [1:0] REG_LEN_B = 2'd1;

endpackage

// ----- rtl/core/ntt_pm_mulmod.sv -----
// ----------------------------------------------------------------------------
// ntt_pm_mulmod
// pipelined modular multiplier, product then reciprocal reduction; the
// reduced result is registered and flagged by fin
// ----------------------------------------------------------------------------
module ntt_pm_mulmod import ntt_pm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [CW-1:0] op_a,
	input  logic [CW-1:0] op_b,
	output logic [CW-1:0] res,
	output logic          fin
);

	logic [CW-1:0]   a_q;
	logic [CW-1:0]   b_q;
	logic [2*CW-1:0] prod_s1;
	logic [CW:0]     quo_s2;
	logic [CW+1:0]   rem_s3;
	logic [CW-1:0]   res_q;
	logic [3:0]      vld_q;
	logic            fin_q;
	logic [2*CW+1:0] qprod;
	logic [CW+1:0]   qp;
	logic [CW+1:0]   red1;
	logic [CW+1:0]   red2;

	// quotient estimate is low by at most two, so the remainder is below 3p
	always_comb begin
		qprod = (2 * CW + 2)'(prod_s1[2*CW-1:CW-1]) * (2 * CW + 2)'(RECIP_MU);
		qp = (CW + 2)'(quo_s2) * (CW + 2)'(MOD_P);
		red1 = (rem_s3 >= (CW + 2)'(MOD_P)) ? (rem_s3 - (CW + 2)'(MOD_P)) : rem_s3;
		red2 = (red1 >= (CW + 2)'(MOD_P)) ? (red1 - (CW + 2)'(MOD_P)) : red1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			fin_q <= 1'b0;
		end else begin
			vld_q <= {vld_q[2:0], go};
			fin_q <= vld_q[3];
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= op_a;
			b_q <= op_b;
		end
		prod_s1 <= (2 * CW)'(a_q) * (2 * CW)'(b_q);
		quo_s2 <= qprod[2*CW+1:CW+1];
		rem_s3 <= prod_s1[CW+1:0] - qp;
		if (vld_q[3])
			res_q <= red2[CW-1:0];
	end

	assign res = res_q;
	assign fin = fin_q;

endmodule

// ----- rtl/core/ntt_polynomial_multiplier_top.sv -----
// ----------------------------------------------------------------------------
// ntt_polynomial_multiplier_top
// polynomial product modulo 998244353 through the number theoretic transform
// ----------------------------------------------------------------------------
// Load and read requests are taken one per cycle while busy is low; a read
// answers on the result ports in the cycle after it is taken, and the
// receiver cannot hold results back. A compute request raises busy until its
// done result. Every butterfly, twiddle step, pointwise product and scaling
// goes through one pipelined modular multiplier, and the work memory has a
// single port.
// Coefficient stores need no clearing after reset.
// ----------------------------------------------------------------------------
module ntt_polynomial_multiplier_top import ntt_pm_pkg::*; #(
	parameter int TRANSFORM_MAX = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	// request channel
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    req_type,
	input  logic [11:0]   index,
	input  logic [CW-1:0] coef_value,
	// configuration write channel
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [11:0]   cfg_data,
	// results
	output logic          result_strobe,
	output logic          result_kind,
	output logic [11:0]   result_index,
	output logic [CW-1:0] product_value
);

	// address width of a store, length width, stage and root index widths
	localparam int AW = $clog2(TRANSFORM_MAX);
	localparam int LW = ((AW > 12) ? AW : 12) + 1;
	localparam int SW = $clog2(AW + 1);
	localparam int RIW = (AW > 1) ? $clog2(AW) : 1;

	// which transform is running
	localparam logic [1:0] PH_A = 2'd0;
	localparam logic [1:0] PH_B = 2'd1;
	localparam logic [1:0] PH_INV = 2'd2;

	// sequencer states
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_RSQ = 5'd1;
	localparam logic [4:0] ST_RSQW = 5'd2;
	localparam logic [4:0] ST_RML = 5'd3;
	localparam logic [4:0] ST_RMLW = 5'd4;
	localparam logic [4:0] ST_RCH = 5'd5;
	localparam logic [4:0] ST_RCHW = 5'd6;
	localparam logic [4:0] ST_CP_RD = 5'd7;
	localparam logic [4:0] ST_CP_WA = 5'd8;
	localparam logic [4:0] ST_CP_WB = 5'd9;
	localparam logic [4:0] ST_BRH = 5'd10;
	localparam logic [4:0] ST_BRL = 5'd11;
	localparam logic [4:0] ST_BWT = 5'd12;
	localparam logic [4:0] ST_BWL = 5'd13;
	localparam logic [4:0] ST_TW = 5'd14;
	localparam logic [4:0] ST_TWW = 5'd15;
	localparam logic [4:0] ST_PW_RA = 5'd16;
	localparam logic [4:0] ST_PW_RB = 5'd17;
	localparam logic [4:0] ST_PW_GO = 5'd18;
	localparam logic [4:0] ST_PW_WT = 5'd19;
	localparam logic [4:0] ST_BV = 5'd20;
	localparam logic [4:0] ST_BV_RI = 5'd21;
	localparam logic [4:0] ST_BV_RJ = 5'd22;
	localparam logic [4:0] ST_BV_WI = 5'd23;
	localparam logic [4:0] ST_BV_WJ = 5'd24;
	localparam logic [4:0] ST_SC_RD = 5'd25;
	localparam logic [4:0] ST_SC_GO = 5'd26;
	localparam logic [4:0] ST_SC_WT = 5'd27;
	localparam logic [4:0] ST_DONE = 5'd28;

	// coefficient stores for both operands, and the work store:
	// bank 0 holds the first operand and later the inverse transform,
	// bank 1 the second operand and later the scaled product
	logic [CW-1:0] a_mem [0:TRANSFORM_MAX-1];
	logic [CW-1:0] b_mem [0:TRANSFORM_MAX-1];
	logic [CW-1:0] wk_mem [0:2*TRANSFORM_MAX-1];

	logic [4:0]    state_q;
	logic [11:0]   len_a_q;
	logic [11:0]   len_b_q;
	logic          prod_valid_q;
	logic [LW:0]   plen_q;
	logic [LW-1:0] la_q;
	logic [LW-1:0] lb_q;
	logic [AW:0]   n_q;
	logic [SW-1:0] l_q;
	logic [CW-1:0] scale_q;

	// sequencer registers
	logic [CW-1:0] acc_q;
	logic [2:0]    pb_q;
	logic [4:0]    e_q;
	logic [CW-1:0] root_q [0:AW-1];
	logic [AW:0]   i_q;
	logic          tb_q;
	logic [1:0]    ph_q;
	logic [SW-1:0] s_q;
	logic [AW:0]   k_q;
	logic [AW:0]   m_q;
	logic [AW:0]   j_q;
	logic [AW:0]   base_q;
	logic [CW-1:0] w_q;
	logic [CW-1:0] sum_q;
	logic [CW-1:0] tmp_q;

	// memory read data
	logic [CW-1:0] a_rd_q;
	logic [CW-1:0] b_rd_q;
	logic [CW-1:0] wk_rd_q;

	// result registers
	logic          strobe_q;
	logic          kind_q;
	logic [11:0]   rindex_q;
	logic          rzero_q;

	// request decode
	logic          accept;
	logic [LW-1:0] idx_ext;
	logic [LW-1:0] la_eff;
	logic [LW-1:0] lb_eff;
	logic [LW-1:0] lon;
	logic [CW:0]   coef_red;
	logic          rd_hit;
	logic [SW-1:0] l_c;
	logic [CW:0]   scale_c;

	// datapath helpers
	logic [AW:0]   hi_full;
	logic [AW:0]   lo_full;
	logic [AW:0]   nb;
	logic [AW:0]   sc_full;
	logic [AW-1:0] rv;
	logic [AW:0]   rv_ext;
	logic [SW-1:0] sm1;
	logic [4:0]    em1;
	logic [CW:0]   bf_sum;
	logic [CW:0]   bf_diff;
	logic [CW-1:0] cp_a;
	logic [CW-1:0] cp_b;

	// work memory port and multiplier port
	logic          wk_re;
	logic          wk_we;
	logic [AW:0]   wk_addr;
	logic [CW-1:0] wk_wdata;
	logic          mul_go;
	logic [CW-1:0] mul_a;
	logic [CW-1:0] mul_b;
	logic [CW-1:0] mul_res;
	logic          mul_fin;

	// register value saturated to 1..TRANSFORM_MAX/2
	function automatic logic [LW-1:0] eff_len(input logic [11:0] v);
		logic [LW-1:0] ve;
		ve = LW'(v);
		if (v == 12'd0)
			return LW'(1);
		if (ve > LW'(TRANSFORM_MAX / 2))
			return LW'(TRANSFORM_MAX / 2);
		return ve;
	endfunction

	function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] v);
		logic [AW-1:0] r;
		for (int b = 0; b < AW; b++)
			r[b] = v[AW-1-b];
		return r;
	endfunction

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign cfg_ready = 1'b1;
	assign idx_ext = LW'(index);
	assign la_eff = eff_len(len_a_q);
	assign lb_eff = eff_len(len_b_q);
	assign lon = (la_eff > lb_eff) ? la_eff : lb_eff;

	// coefficients below 2^30 stay under 2p, so one subtract reduces them
	assign coef_red = ({1'b0, coef_value} >= MOD_P) ? ({1'b0, coef_value} - MOD_P)
		: {1'b0, coef_value};

	assign rd_hit = prod_valid_q && ((LW + 1)'(idx_ext) < plen_q)
		&& (idx_ext < LW'(TRANSFORM_MAX));

	// least transform size at least twice the longer operand
	always_comb begin
		l_c = SW'(AW);
		for (int l = AW; l >= 1; l--) begin
			if (((LW + 1)'(1) << l) >= {lon, 1'b0})
				l_c = SW'(l);
		end
	end

	// 1/n = p - (p-1)/n, since n divides p-1
	assign scale_c = MOD_P - ((MOD_P - (CW + 1)'(1)) >> l_c);

	// butterfly and permutation addresses
	assign lo_full = base_q + j_q;
	assign hi_full = lo_full + k_q;
	assign nb = base_q + m_q;
	assign sc_full = (n_q - i_q) & (n_q - (AW + 1)'(1));
	assign rv = bit_rev(i_q[AW-1:0]) >> (SW'(AW) - l_q);
	assign rv_ext = {1'b0, rv};
	assign sm1 = s_q - SW'(1);
	assign em1 = e_q - 5'd1;

	// butterfly: lo + w*hi and lo - w*hi
	assign bf_sum = ({1'b0, wk_rd_q} + {1'b0, mul_res} >= MOD_P)
		? ({1'b0, wk_rd_q} + {1'b0, mul_res} - MOD_P)
		: ({1'b0, wk_rd_q} + {1'b0, mul_res});
	assign bf_diff = (wk_rd_q >= mul_res) ? ({1'b0, wk_rd_q} - {1'b0, mul_res})
		: ({1'b0, wk_rd_q} + MOD_P - {1'b0, mul_res});

	// zero padding while copying into the work store
	assign cp_a = ((LW + 1)'(i_q) < (LW + 1)'(la_q)) ? a_rd_q : '0;
	assign cp_b = ((LW + 1)'(i_q) < (LW + 1)'(lb_q)) ? b_rd_q : '0;

	ntt_pm_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.res    (mul_res),
		.fin    (mul_fin)
	);

	// work memory port
	always_comb begin
		wk_re = 1'b0;
		wk_we = 1'b0;
		wk_addr = '0;
		wk_wdata = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (req_type == REQ_READ)) begin
					wk_re = 1'b1;
					wk_addr = {1'b1, idx_ext[AW-1:0]};
				end
			end
			ST_CP_WA: begin
				wk_we = 1'b1;
				wk_addr = {1'b0, rv};
				wk_wdata = cp_a;
			end
			ST_CP_WB: begin
				wk_we = 1'b1;
				wk_addr = {1'b1, rv};
				wk_wdata = cp_b;
			end
			ST_BRH: begin
				wk_re = 1'b1;
				wk_addr = {tb_q, hi_full[AW-1:0]};
			end
			ST_BRL: begin
				wk_re = 1'b1;
				wk_addr = {tb_q, lo_full[AW-1:0]};
			end
			ST_BWT: begin
				wk_we = mul_fin;
				wk_addr = {tb_q, hi_full[AW-1:0]};
				wk_wdata = bf_diff[CW-1:0];
			end
			ST_BWL: begin
				wk_we = 1'b1;
				wk_addr = {tb_q, lo_full[AW-1:0]};
				wk_wdata = sum_q;
			end
			ST_PW_RA: begin
				wk_re = 1'b1;
				wk_addr = {1'b0, i_q[AW-1:0]};
			end
			ST_PW_RB: begin
				wk_re = 1'b1;
				wk_addr = {1'b1, i_q[AW-1:0]};
			end
			ST_PW_WT: begin
				wk_we = mul_fin;
				wk_addr = {1'b0, i_q[AW-1:0]};
				wk_wdata = mul_res;
			end
			ST_BV_RI: begin
				wk_re = 1'b1;
				wk_addr = {1'b0, i_q[AW-1:0]};
			end
			ST_BV_RJ: begin
				wk_re = 1'b1;
				wk_addr = {1'b0, rv};
			end
			ST_BV_WI: begin
				wk_we = 1'b1;
				wk_addr = {1'b0, i_q[AW-1:0]};
				wk_wdata = wk_rd_q;
			end
			ST_BV_WJ: begin
				wk_we = 1'b1;
				wk_addr = {1'b0, rv};
				wk_wdata = tmp_q;
			end
			ST_SC_RD: begin
				wk_re = 1'b1;
				wk_addr = {1'b0, sc_full[AW-1:0]};
			end
			ST_SC_WT: begin
				wk_we = mul_fin;
				wk_addr = {1'b1, i_q[AW-1:0]};
				wk_wdata = mul_res;
			end
			default: begin
				wk_re = 1'b0;
			end
		endcase
	end

	// multiplier issue
	always_comb begin
		mul_go = 1'b0;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_RSQ: begin
				mul_go = 1'b1;
				mul_a = acc_q;
				mul_b = acc_q;
			end
			ST_RML: begin
				mul_go = 1'b1;
				mul_a = acc_q;
				mul_b = ROOT_G;
			end
			ST_RCH: begin
				mul_go = (e_q != 5'd1);
				mul_a = acc_q;
				mul_b = acc_q;
			end
			ST_BRL: begin
				mul_go = 1'b1;
				mul_a = wk_rd_q;
				mul_b = w_q;
			end
			ST_TW: begin
				mul_go = 1'b1;
				mul_a = w_q;
				mul_b = root_q[sm1[RIW-1:0]];
			end
			ST_PW_GO: begin
				mul_go = 1'b1;
				mul_a = tmp_q;
				mul_b = wk_rd_q;
			end
			ST_SC_GO: begin
				mul_go = 1'b1;
				mul_a = wk_rd_q;
				mul_b = scale_q;
			end
			default: begin
				mul_go = 1'b0;
			end
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (accept && (req_type == REQ_LOAD_A) && (idx_ext < la_eff))
			a_mem[idx_ext[AW-1:0]] <= coef_red[CW-1:0];
		if (state_q == ST_CP_RD)
			a_rd_q <= a_mem[i_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (accept && (req_type == REQ_LOAD_B) && (idx_ext < lb_eff))
			b_mem[idx_ext[AW-1:0]] <= coef_red[CW-1:0];
		if (state_q == ST_CP_RD)
			b_rd_q <= b_mem[i_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wk_we)
			wk_mem[wk_addr] <= wk_wdata;
		if (wk_re)
			wk_rd_q <= wk_mem[wk_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q <= 12'd1;
			len_b_q <= 12'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LEN_A: len_a_q <= cfg_data;
				REG_LEN_B: len_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prod_valid_q <= 1'b0;
			plen_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (req_type == REQ_READ)) begin
						strobe_q <= 1'b1;
					end else if (accept && (req_type == REQ_COMPUTE)) begin
						plen_q <= (LW + 1)'(la_eff) + (LW + 1)'(lb_eff) - (LW + 1)'(1);
						state_q <= ST_RSQ;
					end
				end
				// root of order 2^23 as 3^119, square and multiply
				ST_RSQ: state_q <= ST_RSQW;
				ST_RSQW: begin
					if (mul_fin) begin
						if (POW_EXP[pb_q])
							state_q <= ST_RML;
						else if (pb_q == 3'd0)
							state_q <= ST_RCH;
						else
							state_q <= ST_RSQ;
					end
				end
				ST_RML: state_q <= ST_RMLW;
				ST_RMLW: begin
					if (mul_fin)
						state_q <= (pb_q == 3'd0) ? ST_RCH : ST_RSQ;
				end
				// squaring chain down to order 2
				ST_RCH: state_q <= (e_q == 5'd1) ? ST_CP_RD : ST_RCHW;
				ST_RCHW: begin
					if (mul_fin)
						state_q <= ST_RCH;
				end
				// copy with zero padding into bit-reversed places
				ST_CP_RD: state_q <= ST_CP_WA;
				ST_CP_WA: state_q <= ST_CP_WB;
				ST_CP_WB: begin
					state_q <= ((i_q + (AW + 1)'(1)) == n_q) ? ST_BRH : ST_CP_RD;
				end
				ST_BRH: state_q <= ST_BRL;
				ST_BRL: state_q <= ST_BWT;
				ST_BWT: begin
					if (mul_fin)
						state_q <= ST_BWL;
				end
				ST_BWL: begin
					if (nb >= n_q) begin
						if ((j_q + (AW + 1)'(1)) == k_q) begin
							if (m_q == n_q) begin
								priority case (ph_q)
									PH_A: state_q <= ST_BRH;
									PH_B: state_q <= ST_PW_RA;
									default: state_q <= ST_SC_RD;
								endcase
							end else begin
								state_q <= ST_BRH;
							end
						end else begin
							state_q <= ST_TW;
						end
					end else begin
						state_q <= ST_BRH;
					end
				end
				ST_TW: state_q <= ST_TWW;
				ST_TWW: begin
					if (mul_fin)
						state_q <= ST_BRH;
				end
				// pointwise product into bank 0
				ST_PW_RA: state_q <= ST_PW_RB;
				ST_PW_RB: state_q <= ST_PW_GO;
				ST_PW_GO: state_q <= ST_PW_WT;
				ST_PW_WT: begin
					if (mul_fin)
						state_q <= ((i_q + (AW + 1)'(1)) == n_q) ? ST_BV : ST_PW_RA;
				end
				// bit-reversal swaps ahead of the inverse transform
				ST_BV: begin
					if (i_q == n_q)
						state_q <= ST_BRH;
					else if (i_q < rv_ext)
						state_q <= ST_BV_RI;
				end
				ST_BV_RI: state_q <= ST_BV_RJ;
				ST_BV_RJ: state_q <= ST_BV_WI;
				ST_BV_WI: state_q <= ST_BV_WJ;
				ST_BV_WJ: state_q <= ST_BV;
				// index reversal and scaling by 1/n into bank 1
				ST_SC_RD: state_q <= ST_SC_GO;
				ST_SC_GO: state_q <= ST_SC_WT;
				ST_SC_WT: begin
					if (mul_fin)
						state_q <= ((i_q + (AW + 1)'(1)) == n_q) ? ST_DONE : ST_SC_RD;
				end
				ST_DONE: begin
					strobe_q <= 1'b1;
					prod_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				kind_q <= RES_COEF;
				rindex_q <= index;
				rzero_q <= !rd_hit;
				la_q <= la_eff;
				lb_q <= lb_eff;
				l_q <= l_c;
				n_q <= (AW + 1)'(1) << l_c;
				scale_q <= scale_c[CW-1:0];
				acc_q <= 30'd1;
				pb_q <= 3'd6;
				e_q <= TWO_ADIC;
			end
			ST_RSQW: begin
				if (mul_fin) begin
					acc_q <= mul_res;
					if (!POW_EXP[pb_q] && (pb_q != 3'd0))
						pb_q <= pb_q - 3'd1;
				end
			end
			ST_RMLW: begin
				if (mul_fin) begin
					acc_q <= mul_res;
					if (pb_q != 3'd0)
						pb_q <= pb_q - 3'd1;
				end
			end
			ST_RCH: begin
				if (e_q <= 5'(AW))
					root_q[em1[RIW-1:0]] <= acc_q;
				i_q <= '0;
			end
			ST_RCHW: begin
				if (mul_fin) begin
					acc_q <= mul_res;
					e_q <= em1;
				end
			end
			ST_CP_WB: begin
				i_q <= i_q + (AW + 1)'(1);
				tb_q <= 1'b0;
				ph_q <= PH_A;
				s_q <= SW'(1);
				k_q <= (AW + 1)'(1);
				m_q <= (AW + 1)'(2);
				j_q <= '0;
				base_q <= '0;
				w_q <= 30'd1;
			end
			ST_BWT: begin
				if (mul_fin)
					sum_q <= bf_sum[CW-1:0];
			end
			ST_BWL: begin
				if (nb >= n_q) begin
					base_q <= '0;
					if ((j_q + (AW + 1)'(1)) == k_q) begin
						j_q <= '0;
						w_q <= 30'd1;
						if (m_q == n_q) begin
							s_q <= SW'(1);
							k_q <= (AW + 1)'(1);
							m_q <= (AW + 1)'(2);
							i_q <= '0;
							if (ph_q == PH_A) begin
								tb_q <= 1'b1;
								ph_q <= PH_B;
							end
						end else begin
							s_q <= s_q + SW'(1);
							k_q <= m_q;
							m_q <= {m_q[AW-1:0], 1'b0};
						end
					end else begin
						j_q <= j_q + (AW + 1)'(1);
					end
				end else begin
					base_q <= nb;
				end
			end
			ST_TWW: begin
				if (mul_fin)
					w_q <= mul_res;
			end
			ST_PW_RB: tmp_q <= wk_rd_q;
			ST_PW_WT: begin
				if (mul_fin) begin
					if ((i_q + (AW + 1)'(1)) == n_q)
						i_q <= '0;
					else
						i_q <= i_q + (AW + 1)'(1);
				end
			end
			ST_BV: begin
				if (i_q == n_q) begin
					tb_q <= 1'b0;
					ph_q <= PH_INV;
					i_q <= '0;
				end else if (!(i_q < rv_ext)) begin
					i_q <= i_q + (AW + 1)'(1);
				end
			end
			ST_BV_RJ: tmp_q <= wk_rd_q;
			ST_BV_WJ: i_q <= i_q + (AW + 1)'(1);
			ST_SC_WT: begin
				if (mul_fin)
					i_q <= i_q + (AW + 1)'(1);
			end
			ST_DONE: begin
				kind_q <= RES_DONE;
				rindex_q <= '0;
				rzero_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign result_strobe = strobe_q;
	assign result_kind = kind_q;
	assign result_index = rindex_q;
	assign product_value = rzero_q ? '0 : wk_rd_q;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the ntt polynomial multiplier: the products are
// predicted by plain convolution modulo p and compared with every read answer
// ----------------------------------------------------------------------------
module testbench;
	import ntt_pm_pkg::*;

	localparam longint unsigned PRIME = 64'd998244353;
	localparam int MAX_N = 4096;

	// one expected answer from the block
	typedef struct packed {
		logic             kind;
		logic [11:0]      idx;
		logic [CW-1:0]    value;
	} answer_t;

	// holds outstanding answers in request order and compares them
	class answer_board;
		answer_t pending_q[$];
		int      errors;
		int      mismatches;
		int      checked;

		function void note(answer_t a);
			pending_q.push_back(a);
		endfunction

		function void check(logic kind, logic [11:0] idx, logic [CW-1:0] value);
			answer_t e;
			if (pending_q.size() == 0) begin
				errors++;
				$display("unexpected answer kind=%0d idx=%0d value=%0d", kind, idx, value);
				return;
			end
			e = pending_q.pop_front();
			checked++;
			if (e.kind !== kind || e.idx !== idx || e.value !== value) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected kind=%0d idx=%0d value=%0d, got kind=%0d idx=%0d value=%0d",
						e.kind, e.idx, e.value, kind, idx, value);
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [1:0]    req_type;
	logic [11:0]   index;
	logic [CW-1:0] coef_value;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [1:0]    cfg_index;
	logic [11:0]   cfg_data;
	logic          result_strobe;
	logic          result_kind;
	logic [11:0]   result_index;
	logic [CW-1:0] product_value;

	ntt_polynomial_multiplier_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.index         (index),
		.coef_value    (coef_value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.result_kind   (result_kind),
		.result_index  (result_index),
		.product_value (product_value)
	);

	answer_board board;

	// mirror of the block state
	logic [11:0]   len_a_reg, len_b_reg;
	logic [CW-1:0] coef_a [MAX_N];
	logic [CW-1:0] coef_b [MAX_N];
	logic [CW-1:0] product [MAX_N];
	int            product_len;
	bit            product_ready;

	bit            no_idle;
	int            items;
	int            computes;
	int            reads;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// saturate a length register to 1 .. half the largest transform
	function automatic int eff_len(logic [11:0] v);
		if (v < 1) return 1;
		if (v > MAX_N / 2) return MAX_N / 2;
		return v;
	endfunction

	// schoolbook product: equal to the transform result since the
	// transform size always covers len_a + len_b - 1
	function automatic void multiply();
		int la, lb;
		longint unsigned acc;
		la = eff_len(len_a_reg);
		lb = eff_len(len_b_reg);
		product_len = la + lb - 1;
		for (int k = 0; k < product_len; k++) begin
			acc = 0;
			for (int i = 0; i < la; i++)
				if (k - i >= 0 && k - i < lb)
					acc = (acc + longint'(coef_a[i]) * longint'(coef_b[k - i])) % PRIME;
			product[k] = acc[CW-1:0];
		end
		product_ready = 1'b1;
	endfunction

	// apply one accepted request to the mirror; returns 1 with an answer
	function automatic bit apply_request(logic [1:0] rt, logic [11:0] idx,
		logic [CW-1:0] val, output answer_t a);
		logic [CW-1:0] red;
		red = CW'(longint'(val) % PRIME);
		a = '0;
		case (rt)
			REQ_LOAD_A: begin
				if (idx < eff_len(len_a_reg)) coef_a[idx] = red;
				return 1'b0;
			end
			REQ_LOAD_B: begin
				if (idx < eff_len(len_b_reg)) coef_b[idx] = red;
				return 1'b0;
			end
			REQ_COMPUTE: begin
				multiply();
				a.kind = RES_DONE;
				return 1'b1;
			end
			default: begin
				a.kind = RES_COEF;
				a.idx = idx;
				if (product_ready && idx < product_len) a.value = product[idx];
				return 1'b1;
			end
		endcase
	endfunction

	// monitor: answers first, then the request taken at this edge
	always @(posedge clk) begin
		answer_t a;
		if (arst_n) begin
			if (result_strobe)
				board.check(result_kind, result_index, product_value);
			if (start && !busy) begin
				if (apply_request(req_type, index, coef_value, a))
					board.note(a);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_LEN_A) len_a_reg <= cfg_data;
				else if (cfg_index == REG_LEN_B) len_b_reg <= cfg_data;
			end
		end
	end

	// all tasks start and end just after a falling edge
	task automatic send(logic [1:0] rt, logic [11:0] idx, logic [CW-1:0] val);
		if (!no_idle)
			while ($urandom_range(99) < 27) begin
				start = 1'b0;
				@(negedge clk);
			end
		start = 1'b1;
		req_type = rt;
		index = idx;
		coef_value = val;
		do @(posedge clk); while (busy);
		@(negedge clk);
		start = 1'b0;
		items++;
		if (rt == REQ_COMPUTE) computes++;
		if (rt == REQ_READ) reads++;
	endtask

	// hold requests until every answer is in, plus a short settle
	task automatic drain();
		while (board.pending_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] r, logic [11:0] d);
		drain();
		cfg_valid = 1'b1;
		cfg_index = r;
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// coefficient value with a bias towards the edges of the field
	function automatic logic [CW-1:0] pick_coef();
		case ($urandom_range(7))
			0: return CW'($urandom_range(32'h3FFF_FFFF, 998244353));
			1: return CW'(PRIME - 1);
			2: return '0;
			default: return CW'($urandom_range(998244352, 0));
		endcase
	endfunction

	// one multiplication: lengths, operands, compute, read back
	task automatic product_round(int la, int lb);
		int plen;
		write_reg(REG_LEN_A, 12'(la));
		write_reg(REG_LEN_B, 12'(lb));
		for (int i = 0; i < la; i++) begin
			send(REQ_LOAD_A, 12'(i), pick_coef());
			// stray load past the end, ignored by the block
			if ($urandom_range(9) == 0)
				send(REQ_LOAD_A, 12'($urandom_range(4095, la)), CW'($urandom));
		end
		for (int i = 0; i < lb; i++) begin
			send(REQ_LOAD_B, 12'(i), pick_coef());
			if ($urandom_range(9) == 0)
				send(REQ_LOAD_B, 12'($urandom_range(4095, lb)), CW'($urandom));
		end
		send(REQ_COMPUTE, 12'($urandom), CW'($urandom));
		plen = la + lb - 1;
		for (int i = 0; i < plen + 2; i++) begin
			if ($urandom_range(5) == 0)
				send(REQ_READ, 12'($urandom), CW'($urandom));
			else
				send(REQ_READ, 12'($urandom_range(plen - 1)), CW'($urandom));
			// loads after compute must leave the product alone
			if ($urandom_range(11) == 0)
				send(REQ_LOAD_A, 12'($urandom_range(la - 1)), pick_coef());
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_LOAD_A;
		index = '0;
		coef_value = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_LEN_A;
		cfg_data = '0;
		len_a_reg = 12'd1;
		len_b_reg = 12'd1;
		product_len = 0;
		product_ready = 1'b0;
		no_idle = 1'b0;
		items = 0;
		computes = 0;
		reads = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reads before any compute give zero
		send(REQ_READ, 12'd0, '0);
		send(REQ_READ, 12'hFFF, '1);
		// small product with field extremes and an unreduced value
		write_reg(REG_LEN_A, 12'd3);
		write_reg(REG_LEN_B, 12'd2);
		send(REQ_LOAD_A, 12'd0, CW'(PRIME - 1));
		send(REQ_LOAD_A, 12'd1, 30'h3FFF_FFFF);
		send(REQ_LOAD_A, 12'd2, '0);
		send(REQ_LOAD_A, 12'd3, 30'h1234_5678);
		send(REQ_LOAD_B, 12'd0, CW'(PRIME - 1));
		send(REQ_LOAD_B, 12'd1, 30'd998244353);
		send(REQ_LOAD_B, 12'hFFF, 30'd7);
		send(REQ_COMPUTE, '0, '0);
		for (int i = 0; i < 5; i++)
			send(REQ_READ, 12'(i), '0);
		send(REQ_READ, 12'hFFF, '0);
		send(REQ_LOAD_A, 12'd0, 30'd5);
		send(REQ_READ, 12'd0, '0);

		// out-of-range and largest lengths: loads and reads only, without a
		// full-size transform
		write_reg(REG_LEN_A, 12'd0);
		write_reg(REG_LEN_B, 12'hFFF);
		send(REQ_LOAD_A, 12'd1, 30'd9);
		send(REQ_LOAD_B, 12'd2047, 30'd9);
		send(REQ_LOAD_B, 12'd2048, 30'd9);
		write_reg(REG_LEN_A, 12'd2048);
		write_reg(REG_LEN_B, 12'd2048);
		send(REQ_LOAD_A, 12'd2047, 30'd1);
		send(REQ_READ, 12'd2, '0);

		// random rounds: one medium size, then mostly tiny ones
		product_round(64, $urandom_range(64, 1));
		while (items < 620) begin
			no_idle = (computes >= 10 && computes < 14);
			if ($urandom_range(3) == 0)
				product_round($urandom_range(16, 1), $urandom_range(16, 1));
			else
				product_round($urandom_range(6, 1), $urandom_range(6, 1));
			// sender waits for every outstanding answer once in a while
			if ($urandom_range(4) == 0) drain();
		end
		no_idle = 1'b0;

		while (board.pending_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("ran %0d requests: %0d computes, %0d reads, %0d answers checked",
			items, computes, reads, board.checked);
		$display("lengths from zero up to saturation, stray and unreduced loads included");
		if (board.errors == 0 && board.pending_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d errors, %0d mismatches", board.errors, board.mismatches);
			$display("Verification failed");
		end
		$finish;
	end

	// watchdog against a hung block
	initial begin
		#200ms;
		$display("Verification failed");
		$finish;
	end

endmodule

// ----- ntt_polynomial_multiplier_top.f -----
rtl/core/ntt_pm_pkg.sv
rtl/core/ntt_pm_mulmod.sv
rtl/core/ntt_polynomial_multiplier_top.sv
sim/testbench.sv
